// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the virtual timer bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define VTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define VTB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/vtb_pkg.sv
// Shared constants and item types of the virtual timer bank
package vtb_pkg;

  localparam int NumTimers = 8;
  localparam int PinCount  = 16;

  localparam int CountW    = 32;
  localparam int PinW      = 4;
  localparam int MaskW     = 16;
  localparam int FlagW     = 8;
  localparam int IdW       = 3;
  localparam int UsedW     = $clog2(NumTimers + 1);

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CountW-1:0] timeout_count;
    logic [PinW-1:0]   out_pin;
    logic              periodic;
  } vtb_in_t;

  typedef struct packed {
    logic [MaskW-1:0] toggle_mask;
    logic [FlagW-1:0] fired_flags;
    logic [IdW-1:0]   new_id;
    logic             bank_full;
  } vtb_out_t;

  // broadcast control seen by every timer cell
  typedef struct packed {
    logic              tick;
    logic              add;
    logic [CountW-1:0] timeout;
    logic [PinW-1:0]   pin;
    logic              periodic;
  } vtb_cell_ctrl_t;

endpackage

// File: hw/rtl/vtb_cell.sv
// One timer cell: holds a single timer and passes the slot token and toggle mask on
module vtb_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vtb_pkg::vtb_cell_ctrl_t       ctrl_i,
  input  logic                          claim_i,
  output logic                          claim_o,
  input  logic [vtb_pkg::MaskW-1:0]     mask_i,
  output logic [vtb_pkg::MaskW-1:0]     mask_o,
  output logic                          ready_next_o
);

  logic                          used_q, used_d;
  logic                          active_q, active_d;
  logic                          mode_q, mode_d;
  logic                          ready_q, ready_d;
  logic [vtb_pkg::PinW-1:0]      pin_q, pin_d;
  logic [vtb_pkg::CountW-1:0]    limit_q, limit_d;
  logic [vtb_pkg::CountW-1:0]    count_q, count_d;
  logic                          hit;
  logic                          fire;
  logic                          take;
  logic [vtb_pkg::MaskW-1:0]     pin_bit;

  // timeout reached, fire on a tick while enabled
  assign hit  = (count_q >= limit_q);
  assign fire = ctrl_i.tick && active_q && hit;

  // the first unused slot takes an add; pass the token past used slots
  assign take    = ctrl_i.add && claim_i && !used_q;
  assign claim_o = claim_i && used_q;

  // decode the pin; pins beyond the pin count toggle nothing
  always_comb begin
    pin_bit = '0;
    for (int j = 0; j < vtb_pkg::PinCount && j < vtb_pkg::MaskW; j++) begin
      pin_bit[j] = (pin_q == vtb_pkg::PinW'(j));
    end
  end

  assign mask_o = fire ? (mask_i ^ pin_bit) : mask_i;

  // next state of the timer
  always_comb begin
    used_d   = used_q;
    active_d = active_q;
    mode_d   = mode_q;
    ready_d  = ready_q;
    pin_d    = pin_q;
    limit_d  = limit_q;
    count_d  = count_q;
    if (take) begin
      used_d   = 1'b1;
      active_d = 1'b1;
      mode_d   = ctrl_i.periodic;
      ready_d  = 1'b0;
      pin_d    = ctrl_i.pin;
      limit_d  = ctrl_i.timeout;
      count_d  = '0;
    end else if (ctrl_i.tick && active_q) begin
      if (hit) begin
        ready_d = 1'b1;
        if (mode_q) begin
          count_d = '0;
        end else begin
          active_d = 1'b0;
        end
      end else begin
        count_d = count_q + vtb_pkg::CountW'(1);
        ready_d = 1'b0;
      end
    end
  end

  assign ready_next_o = ready_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      active_q <= 1'b0;
      mode_q   <= 1'b0;
      ready_q  <= 1'b0;
      pin_q    <= '0;
      limit_q  <= '0;
      count_q  <= '0;
    end else begin
      used_q   <= used_d;
      active_q <= active_d;
      mode_q   <= mode_d;
      ready_q  <= ready_d;
      pin_q    <= pin_d;
      limit_q  <= limit_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hw/rtl/virtual_timer_bank_unit.sv
// Virtual timer bank top level: row of timer cells and the result register
// Latency: the result of an item is shown with done_o in the cycle after start_i.
// Throughput: one item per cycle; busy_o is never raised, every timer cell
// updates in parallel and the toggle mask ripples through the cell row.
// Reset: clears every timer (all disabled, flags low) and the slot count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module virtual_timer_bank_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  vtb_pkg::vtb_in_t  item_i,
  output logic              done_o,
  output vtb_pkg::vtb_out_t result_o
);

  logic                          accept;
  vtb_pkg::vtb_cell_ctrl_t       ctrl;
  logic [vtb_pkg::NumTimers:0]   claim;
  logic [vtb_pkg::MaskW-1:0]     mask [vtb_pkg::NumTimers+1];
  logic [vtb_pkg::NumTimers-1:0] ready_next;
  logic                          full;
  logic [vtb_pkg::UsedW-1:0]     used_q, used_d;
  logic                          done_q;
  vtb_pkg::vtb_out_t             out_q, out_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // broadcast the item to the cells
  always_comb begin
    ctrl.tick     = accept && (item_i.cmd == vtb_pkg::CMD_TICK);
    ctrl.add      = accept && (item_i.cmd == vtb_pkg::CMD_ADD);
    ctrl.timeout  = item_i.timeout_count;
    ctrl.pin      = item_i.out_pin;
    ctrl.periodic = item_i.periodic;
  end

  assign claim[0] = 1'b1;
  assign mask[0]  = '0;

  for (genvar i = 0; i < vtb_pkg::NumTimers; i++) begin : g_cell
    vtb_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .claim_i      (claim[i]),
      .claim_o      (claim[i+1]),
      .mask_i       (mask[i]),
      .mask_o       (mask[i+1]),
      .ready_next_o (ready_next[i])
    );
  end

  // token ran past every cell: no free slot left
  assign full = claim[vtb_pkg::NumTimers];

  // advance the slot count on a successful add
  always_comb begin
    used_d = used_q;
    if (ctrl.add && !full) begin
      used_d = used_q + vtb_pkg::UsedW'(1);
    end
  end

  // assemble the result
  always_comb begin
    out_d             = '0;
    out_d.toggle_mask = ctrl.tick ? mask[vtb_pkg::NumTimers] : '0;
    for (int i = 0; i < vtb_pkg::NumTimers && i < vtb_pkg::FlagW; i++) begin
      out_d.fired_flags[i] = ready_next[i];
    end
    if (ctrl.add) begin
      out_d.bank_full = full;
      out_d.new_id    = full ? '0 : vtb_pkg::IdW'(used_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      done_q <= 1'b0;
    end else begin
      used_q <= used_d;
      done_q <= accept;
    end
  end

  // hold the result until the next accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

// File: hw/rtl/vtb_checker.sv
// Port-level checker of the virtual timer bank, bound to the top level
`include "assert_macros.svh"

module vtb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input vtb_pkg::vtb_in_t  item_i,
  input logic              done_o,
  input vtb_pkg::vtb_out_t result_o
);

  // every accepted item gives a result in the next cycle, and only then
  `VTB_ASSERT(a_done_follows, (start_i && !busy_o) |=> done_o, "accepted item gave no result")
  `VTB_ASSERT(a_no_spurious, !(start_i && !busy_o) |=> !done_o, "result without an item")
  // a full bank stores nothing and toggles nothing
  `VTB_ASSERT(a_full_clean, (done_o && result_o.bank_full) |-> (result_o.new_id == '0 && result_o.toggle_mask == '0), "full result carries data")
  // a tick never reports a slot or a full bank
  `VTB_ASSERT(a_tick_fields, (start_i && !busy_o && item_i.cmd == vtb_pkg::CMD_TICK) |=> (!result_o.bank_full && result_o.new_id == '0), "tick result has add fields")
  // no strobe while reset is held
  `VTB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "result during reset")

endmodule

bind virtual_timer_bank_unit vtb_checker u_vtb_checker (.*);
